// ----- design/tcpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types and constants of the two-class priority queue
// Holds the result status codes, default sizes and the control structs
// passed between the top level and the class FIFOs.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

  localparam int DATA_W              = 32;
  localparam int STATUS_W            = 2;
  localparam int DEFAULT_CLASS_DEPTH = 16;

  localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = 32'sd59;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_REMOVED  = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Requests from the top level to one class FIFO.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  // Occupancy flags reported by one class FIFO.
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_flags_t;

endpackage : tcpq_pkg

`default_nettype wire

// ----- design/tcpq_fifo.sv -----
// ----------------------------------------------------------------------------
// tcpq_fifo: circular FIFO for one priority class
// Keeps a head pointer and fill count, stores entries in a memory and holds
// the oldest entry in a front register so a pop needs no memory read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_fifo #(
  parameter int DEPTH  = tcpq_pkg::DEFAULT_CLASS_DEPTH,
  parameter int FILL_W = $clog2(DEPTH + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire tcpq_pkg::fifo_ctrl_t           ctrl,
  input  wire logic [tcpq_pkg::DATA_W-1:0]    wr_data,
  output tcpq_pkg::fifo_flags_t               flags,
  output logic [FILL_W-1:0]                   fill,
  output logic [tcpq_pkg::DATA_W-1:0]         front
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int SUM_W = FILL_W + 1;

  logic [tcpq_pkg::DATA_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  head_next;
  logic [FILL_W-1:0] fill_next;
  logic [IDX_W-1:0]  tail;
  logic [SUM_W-1:0]  tail_sum;

  assign flags.empty = (fill == '0);
  assign flags.full  = (fill == FILL_W'(DEPTH));

  // Tail is head + fill, wrapped once at the depth.
  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(fill);
    if (tail_sum >= SUM_W'(DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(DEPTH);
    end
    tail = tail_sum[IDX_W-1:0];
  end

  always_comb begin
    head_next = head;
    fill_next = fill;
    if (ctrl.pop) begin
      head_next = (head == IDX_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      fill_next = fill - 1'b1;
    end else if (ctrl.push) begin
      fill_next = fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail] <= wr_data;
    end
  end

  // Front register tracks the entry at the new head; forward the write data
  // when a push lands in an empty FIFO.
  always_ff @(posedge clk) begin
    if (ctrl.push && (tail == head_next)) begin
      front <= wr_data;
    end else begin
      front <= mem[head_next];
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("tcpq_fifo: fill count beyond depth");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |-> !flags.full)
    else $error("tcpq_fifo: push into a full FIFO");

endmodule : tcpq_fifo

`default_nettype wire

// ----- design/two_class_priority_queue.sv -----
// ----------------------------------------------------------------------------
// two_class_priority_queue: strict priority queue with two classes
// Insert and remove transactions on signed 32-bit values, served from a
// priority FIFO and a normal FIFO chosen by a programmable threshold.
// ----------------------------------------------------------------------------
// Each input transaction is either an insert (op 0) or a remove (op 1) and
// yields exactly one result transaction. An inserted value strictly greater
// than priority_threshold (signed, reset 59, written through cfg_wr_en and
// cfg_wr_data) joins the priority class; any other value, including one equal
// to the threshold, joins the normal class. A remove returns the oldest
// priority entry, or the oldest normal entry when the priority class is empty.
// Status is 0 inserted, 1 removed, 2 both classes empty on remove, 3 class
// full on insert (the value is dropped). removed_value is zero unless an
// entry was removed, and total_count gives the entries held in both classes
// after the transaction. The block accepts one transaction per clock cycle
// while in_stall is low. A transaction passes through the input register,
// where the FIFO pointers, fill counts and front registers update, and
// then through the result register. Each class memory has one write and one
// registered read per cycle, with the read always aimed at the next head, so
// a remove never waits on memory. Back-pressure on the result side holds the
// input register and raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_priority_queue #(
  parameter int CLASS_DEPTH = tcpq_pkg::DEFAULT_CLASS_DEPTH,
  parameter int COUNT_W     = $clog2(2 * CLASS_DEPTH + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_wr_en,
  input  wire logic signed [tcpq_pkg::DATA_W-1:0]  cfg_wr_data,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                op,
  input  wire logic signed [tcpq_pkg::DATA_W-1:0]  value,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [tcpq_pkg::STATUS_W-1:0]            status,
  output logic signed [tcpq_pkg::DATA_W-1:0]       removed_value,
  output logic [COUNT_W-1:0]                       total_count
);

  localparam int FILL_W = $clog2(CLASS_DEPTH + 1);

  // Threshold register
  logic signed [tcpq_pkg::DATA_W-1:0] threshold;

  // Input register
  logic                               req_valid;
  tcpq_pkg::op_t                      req_op;
  logic signed [tcpq_pkg::DATA_W-1:0] req_value;

  logic accept;
  logic advance;

  // FIFO interfaces
  tcpq_pkg::fifo_ctrl_t        prio_ctrl;
  tcpq_pkg::fifo_ctrl_t        norm_ctrl;
  tcpq_pkg::fifo_flags_t       prio_flags;
  tcpq_pkg::fifo_flags_t       norm_flags;
  logic [FILL_W-1:0]           prio_fill;
  logic [FILL_W-1:0]           norm_fill;
  logic [tcpq_pkg::DATA_W-1:0] prio_front;
  logic [tcpq_pkg::DATA_W-1:0] norm_front;

  // Result of the transaction in the input register
  tcpq_pkg::status_t                  status_next;
  logic signed [tcpq_pkg::DATA_W-1:0] removed_next;
  logic [COUNT_W-1:0]                 count_next;
  logic                               to_prio;

  // Process the held request whenever the result register is free or drains
  // this cycle; hold the input register otherwise.
  assign advance  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= tcpq_pkg::THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (accept) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= tcpq_pkg::op_t'(op);
      req_value <= value;
    end
  end

  // Classify, pick the FIFO to touch and build the result.
  always_comb begin
    to_prio      = (req_value > threshold);
    prio_ctrl    = '0;
    norm_ctrl    = '0;
    removed_next = '0;
    status_next  = tcpq_pkg::STATUS_EMPTY;
    count_next   = COUNT_W'(prio_fill) + COUNT_W'(norm_fill);
    case (req_op)
      tcpq_pkg::OP_INSERT: begin
        if ((to_prio && prio_flags.full) || (!to_prio && norm_flags.full)) begin
          // drop the value, report a full class
          status_next = tcpq_pkg::STATUS_FULL;
        end else begin
          prio_ctrl.push = advance && to_prio;
          norm_ctrl.push = advance && !to_prio;
          status_next    = tcpq_pkg::STATUS_INSERTED;
          count_next     = count_next + 1'b1;
        end
      end
      tcpq_pkg::OP_REMOVE: begin
        if (!prio_flags.empty) begin
          prio_ctrl.pop = advance;
          removed_next  = prio_front;
          status_next   = tcpq_pkg::STATUS_REMOVED;
          count_next    = count_next - 1'b1;
        end else if (!norm_flags.empty) begin
          norm_ctrl.pop = advance;
          removed_next  = norm_front;
          status_next   = tcpq_pkg::STATUS_REMOVED;
          count_next    = count_next - 1'b1;
        end else begin
          status_next = tcpq_pkg::STATUS_EMPTY;
        end
      end
      default: begin
        status_next = tcpq_pkg::STATUS_EMPTY;
      end
    endcase
  end

  tcpq_fifo #(
    .DEPTH  (CLASS_DEPTH),
    .FILL_W (FILL_W)
  ) u_prio_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (prio_ctrl),
    .wr_data (req_value),
    .flags   (prio_flags),
    .fill    (prio_fill),
    .front   (prio_front)
  );

  tcpq_fifo #(
    .DEPTH  (CLASS_DEPTH),
    .FILL_W (FILL_W)
  ) u_norm_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (norm_ctrl),
    .wr_data (req_value),
    .flags   (norm_flags),
    .fill    (norm_fill),
    .front   (norm_front)
  );

  // Result register: load on advance, drop once the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status        <= status_next;
      removed_value <= removed_next;
      total_count   <= count_next;
    end
  end

  a_strict_priority: assert property (@(posedge clk) disable iff (rst)
    norm_ctrl.pop |-> prio_flags.empty)
    else $error("two_class_priority_queue: normal entry left before a priority one");

  a_empty_means_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == tcpq_pkg::STATUS_EMPTY)) |-> (total_count == '0))
    else $error("two_class_priority_queue: empty status with entries held");

  a_zero_unless_removed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != tcpq_pkg::STATUS_REMOVED)) |-> (removed_value == '0))
    else $error("two_class_priority_queue: removed value set without a remove");

  a_one_fifo_touched: assert property (@(posedge clk) disable iff (rst)
    $countones({prio_ctrl.push, prio_ctrl.pop, norm_ctrl.push, norm_ctrl.pop}) <= 1)
    else $error("two_class_priority_queue: more than one FIFO update per transaction");

endmodule : two_class_priority_queue

`default_nettype wire
